/* sv/sgdb_pkg.sv */
// Shared types and constants of the scatter-gather descriptor builder.
// No dependencies; imported by the engine, the result queue and the top level.
`default_nettype none

package sgdb_pkg;

   localparam int SLOT_W     = 6;
   localparam int SIZE_W     = 32;
   localparam int ADDR_W     = 64;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 64;

   // Register indexes of the control port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_JOB_SIZE       = 8'd0,
      CSR_START_OFFSET   = 8'd1,
      CSR_DEVICE_ADDRESS = 8'd2,
      CSR_TO_HOST        = 8'd3
   } csr_index_type;

   // Job setup as held in the control registers
   typedef struct packed {
      logic [SIZE_W-1:0] job_size;
      logic [SIZE_W-1:0] start_offset;
      logic [ADDR_W-1:0] device_address;
      logic              to_host;
   } csr_type;

   // One descriptor word on the result side
   typedef struct packed {
      logic              is_terminator;
      logic [SLOT_W-1:0] slot;
      logic [SIZE_W-1:0] byte_count;
      logic [ADDR_W-1:0] source_address;
      logic [ADDR_W-1:0] dest_address;
      logic              job_done;
      logic              last_of_run;
   } rsp_type;

   // Push request from the engine into the result queue
   typedef struct packed {
      logic push_one;
      logic push_two;
   } push_type;

endpackage : sgdb_pkg

`default_nettype wire

/* sv/sgdb_engine.sv */
// Input register and descriptor generation with the running job state.
// Depends on sgdb_pkg; feeds sgdb_rsp_queue.
`default_nettype none

module sgdb_engine #(
   parameter int MAX_SLOTS = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic                      req_first_of_job,
   input  wire logic                      req_last_entry,
   input  wire logic [63:0]               req_host_address,
   input  wire logic [31:0]               req_entry_length,
   input  wire sgdb_pkg::csr_type         csr,
   input  wire logic                      queue_space,
   output sgdb_pkg::push_type             push,
   output sgdb_pkg::rsp_type              rsp0,
   output sgdb_pkg::rsp_type              rsp1
);
   import sgdb_pkg::*;

   localparam int CNT_MIN = $clog2(MAX_SLOTS + 1);
   localparam int CNT_W   = (CNT_MIN > SLOT_W) ? CNT_MIN : SLOT_W;

   // Input register
   logic              in_valid_ff, in_valid_in;
   logic              first_ff, last_ff;
   logic [ADDR_W-1:0] host_ff;
   logic [SIZE_W-1:0] len_ff;

   // Job state
   logic [SIZE_W-1:0] remaining_ff, remaining_in;
   logic [SIZE_W-1:0] offset_ff, offset_in;
   logic [ADDR_W-1:0] cursor_ff, cursor_in;
   logic [CNT_W-1:0]  slot_ff, slot_in;
   logic              active_ff, active_in;

   logic              req_take, advance;
   logic [SIZE_W-1:0] eff_remaining, eff_offset, avail, tr, rem_next;
   logic [ADDR_W-1:0] eff_cursor, haddr;
   logic [CNT_W-1:0]  eff_slot, slot_next;
   logic              eff_active, skip;

   assign advance   = in_valid_ff && queue_space;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   // Hold the entry until the result queue can take its words
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         first_ff <= req_first_of_job;
         last_ff  <= req_last_entry;
         host_ff  <= req_host_address;
         len_ff   <= req_entry_length;
      end
   end

   // Reload the job from the registers on the first entry
   always_comb begin
      eff_remaining = first_ff ? csr.job_size       : remaining_ff;
      eff_offset    = first_ff ? csr.start_offset   : offset_ff;
      eff_cursor    = first_ff ? csr.device_address : cursor_ff;
      eff_slot      = first_ff ? '0                 : slot_ff;
      eff_active    = first_ff || active_ff;
      skip          = eff_offset > len_ff;
      avail         = len_ff - eff_offset;
      haddr         = host_ff + ADDR_W'(eff_offset);
      tr            = (avail < eff_remaining) ? avail : eff_remaining;
      rem_next      = eff_remaining - tr;
      slot_next     = eff_slot + CNT_W'(1);
   end

   // Build descriptor words and next job state
   always_comb begin
      push          = '0;
      rsp0          = '0;
      rsp1          = '0;
      remaining_in  = remaining_ff;
      offset_in     = offset_ff;
      cursor_in     = cursor_ff;
      slot_in       = slot_ff;
      active_in     = active_ff;
      rsp1.is_terminator = 1'b1;
      rsp1.slot          = slot_next[SLOT_W-1:0];
      rsp1.last_of_run   = 1'b1;
      if (advance && eff_active) begin
         remaining_in = eff_remaining;
         cursor_in    = eff_cursor;
         slot_in      = eff_slot;
         active_in    = 1'b1;
         if (skip) begin
            // drop the whole entry into the offset
            offset_in = eff_offset - len_ff;
            if (last_ff) begin
               push.push_one      = 1'b1;
               rsp0.is_terminator = 1'b1;
               rsp0.slot          = eff_slot[SLOT_W-1:0];
               rsp0.job_done      = 1'b1;
               rsp0.last_of_run   = 1'b1;
               slot_in            = '0;
               active_in          = 1'b0;
            end
         end else begin
            offset_in          = '0;
            push.push_one      = 1'b1;
            rsp0.slot          = eff_slot[SLOT_W-1:0];
            rsp0.byte_count    = tr;
            rsp0.source_address = csr.to_host ? eff_cursor : haddr;
            rsp0.dest_address   = csr.to_host ? haddr : eff_cursor;
            cursor_in          = eff_cursor + ADDR_W'(tr);
            remaining_in       = rem_next;
            slot_in            = slot_next;
            if (rem_next == '0 || last_ff) begin
               push.push_two = 1'b1;
               rsp1.job_done = 1'b1;
               slot_in       = '0;
               active_in     = 1'b0;
            end else if (slot_next >= CNT_W'(MAX_SLOTS)) begin
               // chunk full: close it and keep the job running
               push.push_two = 1'b1;
               slot_in       = '0;
            end else begin
               rsp0.last_of_run = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= '0;
         offset_ff    <= '0;
         cursor_ff    <= '0;
         slot_ff      <= '0;
         active_ff    <= 1'b0;
      end else begin
         remaining_ff <= remaining_in;
         offset_ff    <= offset_in;
         cursor_ff    <= cursor_in;
         slot_ff      <= slot_in;
         active_ff    <= active_in;
      end
   end

endmodule : sgdb_engine

`default_nettype wire

/* sv/sgdb_rsp_queue.sv */
// Four-word result queue between descriptor generation and the result port.
// Depends on sgdb_pkg; takes up to two words per cycle, gives one per cycle unless stalled.
`default_nettype none

module sgdb_rsp_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire sgdb_pkg::push_type push,
   input  wire sgdb_pkg::rsp_type  rsp0,
   input  wire sgdb_pkg::rsp_type  rsp1,
   output logic                    queue_space,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output sgdb_pkg::rsp_type       rsp_head
);
   import sgdb_pkg::*;

   localparam int DEPTH = 4;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rsp_type           q_ff [DEPTH];
   rsp_type           q_in [DEPTH];
   logic [CNT_W-1:0]  cnt_ff, cnt_in, base;
   logic              pop;

   assign rsp_valid   = cnt_ff != '0;
   assign rsp_head    = q_ff[0];
   assign pop         = rsp_valid && !rsp_stall;
   assign queue_space = cnt_ff <= CNT_W'(DEPTH - 2);

   // Shift out the head word, then append new words behind the rest
   always_comb begin
      base = cnt_ff - CNT_W'(pop);
      for (int i = 0; i < DEPTH; i++) begin
         q_in[i] = q_ff[i];
      end
      if (pop) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            q_in[i] = q_ff[i + 1];
         end
      end
      for (int i = 0; i < DEPTH; i++) begin
         if (push.push_one && base == CNT_W'(i)) begin
            q_in[i] = rsp0;
         end
         if (push.push_two && base + CNT_W'(1) == CNT_W'(i)) begin
            q_in[i] = rsp1;
         end
      end
      cnt_in = base + CNT_W'(push.push_one) + CNT_W'(push.push_two);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

endmodule : sgdb_rsp_queue

`default_nettype wire

/* sv/sg_to_dma_descriptor_builder_top.sv */
// Top level of the scatter-gather to DMA descriptor builder.
// Depends on sgdb_pkg, sgdb_engine and sgdb_rsp_queue.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    first_of_job, last_entry, host_address,
//                                          entry_length
//   rsp      out        rsp_valid/stall    one descriptor word
//   csr      in         csr_valid/ready    csr_index, csr_wdata
//
// One entry is taken per cycle while the result queue has space; its words pass
// the input register and the queue, then leave the result port one per cycle
// while rsp_stall is low. An entry that makes a descriptor and a terminator puts
// two words into the queue, so a stream of such entries fills it and raises req_stall.
// Reset is synchronous and clears the job state and the result queue.
// A stall on the result side backs up through the four-word queue to req_stall.
`default_nettype none

module sg_to_dma_descriptor_builder_top #(
   parameter int MAX_SLOTS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_first_of_job,
   input  wire logic        req_last_entry,
   input  wire logic [63:0] req_host_address,
   input  wire logic [31:0] req_entry_length,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_is_terminator,
   output logic [5:0]       rsp_slot,
   output logic [31:0]      rsp_byte_count,
   output logic [63:0]      rsp_source_address,
   output logic [63:0]      rsp_dest_address,
   output logic             rsp_job_done,
   output logic             rsp_last_of_run,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);
   import sgdb_pkg::*;

   csr_type  csr_ff, csr_in;
   push_type push;
   rsp_type  rsp0, rsp1, rsp_head;
   logic     queue_space;

   assign csr_ready = 1'b1;

   // Write the addressed control register, drop unknown indexes
   always_comb begin
      csr_in = csr_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_JOB_SIZE:       csr_in.job_size       = csr_wdata[SIZE_W-1:0];
            CSR_START_OFFSET:   csr_in.start_offset   = csr_wdata[SIZE_W-1:0];
            CSR_DEVICE_ADDRESS: csr_in.device_address = csr_wdata;
            CSR_TO_HOST:        csr_in.to_host        = csr_wdata[0];
            default:            csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '0;
      end else begin
         csr_ff <= csr_in;
      end
   end

   sgdb_engine #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_first_of_job (req_first_of_job),
      .req_last_entry   (req_last_entry),
      .req_host_address (req_host_address),
      .req_entry_length (req_entry_length),
      .csr              (csr_ff),
      .queue_space      (queue_space),
      .push             (push),
      .rsp0             (rsp0),
      .rsp1             (rsp1)
   );

   sgdb_rsp_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .rsp0        (rsp0),
      .rsp1        (rsp1),
      .queue_space (queue_space),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_head    (rsp_head)
   );

   // Split the head word onto the result ports
   assign rsp_is_terminator  = rsp_head.is_terminator;
   assign rsp_slot           = rsp_head.slot;
   assign rsp_byte_count     = rsp_head.byte_count;
   assign rsp_source_address = rsp_head.source_address;
   assign rsp_dest_address   = rsp_head.dest_address;
   assign rsp_job_done       = rsp_head.job_done;
   assign rsp_last_of_run    = rsp_head.last_of_run;

endmodule : sg_to_dma_descriptor_builder_top

`default_nettype wire

/* sv/sgdb_checker.sv */
// Port-level checks of the descriptor builder, bound to the top level.
// Depends only on the ports of sg_to_dma_descriptor_builder_top.
`default_nettype none

module sgdb_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_is_terminator,
   input wire logic [5:0]  rsp_slot,
   input wire logic [31:0] rsp_byte_count,
   input wire logic [63:0] rsp_source_address,
   input wire logic [63:0] rsp_dest_address,
   input wire logic        rsp_job_done,
   input wire logic        rsp_last_of_run
);

   // No word right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present after reset");

   // A stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_is_terminator)
         && $stable(rsp_slot) && $stable(rsp_byte_count)
         && $stable(rsp_source_address) && $stable(rsp_dest_address)
         && $stable(rsp_job_done) && $stable(rsp_last_of_run))
      else $error("stalled result word changed");

   // A terminator moves nothing
   a_term_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_terminator |-> rsp_byte_count == 32'd0
         && rsp_source_address == 64'd0 && rsp_dest_address == 64'd0
         && rsp_last_of_run)
      else $error("terminator carries data");

   // Job end only on a terminator
   a_done_term: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_job_done |-> rsp_is_terminator)
      else $error("job end on a data descriptor");

   // A data word that is not last is followed at once by its terminator
   a_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_is_terminator && !rsp_last_of_run
         |=> rsp_valid && rsp_is_terminator)
      else $error("terminator missing after data descriptor");

endmodule : sgdb_checker

bind sg_to_dma_descriptor_builder_top sgdb_checker u_sgdb_checker (.*);

`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for the scatter-gather to DMA descriptor builder.
// Predicts every descriptor word from the entries it feeds and checks what leaves
// the result port; depends on sgdb_pkg and sg_to_dma_descriptor_builder_top.
`timescale 1ns / 100ps

module tb_top;
   import sgdb_pkg::*;

   localparam int CHUNK_SLOTS   = 32;
   localparam int SETTLE_CYCLES = 10;
   localparam int LONG_HOLD     = 400;
   localparam int MAX_REPORTS   = 10;
   localparam int RUN_LIMIT_NS  = 8_000_000;

   // Pacing styles of either side of the ports
   localparam int PACE_FULL   = 0;
   localparam int PACE_RANDOM = 1;
   localparam int PACE_SPARSE = 2;

   // A register index outside the list, which the block must ignore
   localparam logic [CSR_IDX_W-1:0] CSR_NO_SUCH_REG = 8'hA5;

   typedef struct packed {
      logic        first_of_job;
      logic        last_entry;
      logic [63:0] host_address;
      logic [31:0] entry_length;
   } sg_entry_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_first_of_job = 1'b0;
   logic        req_last_entry = 1'b0;
   logic [63:0] req_host_address = '0;
   logic [31:0] req_entry_length = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_is_terminator;
   logic [5:0]  rsp_slot;
   logic [31:0] rsp_byte_count;
   logic [63:0] rsp_source_address;
   logic [63:0] rsp_dest_address;
   logic        rsp_job_done;
   logic        rsp_last_of_run;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;

   sg_to_dma_descriptor_builder_top #(.MAX_SLOTS(CHUNK_SLOTS)) DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_first_of_job   (req_first_of_job),
      .req_last_entry     (req_last_entry),
      .req_host_address   (req_host_address),
      .req_entry_length   (req_entry_length),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_is_terminator  (rsp_is_terminator),
      .rsp_slot           (rsp_slot),
      .rsp_byte_count     (rsp_byte_count),
      .rsp_source_address (rsp_source_address),
      .rsp_dest_address   (rsp_dest_address),
      .rsp_job_done       (rsp_job_done),
      .rsp_last_of_run    (rsp_last_of_run),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #(RUN_LIMIT_NS);
      $display("*** FAILED ***");
      $finish;
   end

   // Shadow registers and job state of the descriptor builder
   csr_type     job_regs = '0;
   logic [31:0] bytes_left = '0;
   logic [31:0] skip_left = '0;
   logic [63:0] dev_cursor = '0;
   logic [8:0]  slot_cnt = '0;
   logic        job_open = 1'b0;

   rsp_type      descriptor_queue[$];
   sg_entry_type entry_queue[$];

   int  items_pushed = 0;
   int  items_accepted = 0;
   int  errors = 0;
   int  holds_asked = 0;
   int  holds_served = 0;
   bit  req_taken = 1'b0;
   bit  rsp_taken = 1'b0;

   function automatic rsp_type make_terminator(input logic [8:0] slot, input logic done);
      rsp_type w;
      w = '0;
      w.is_terminator = 1'b1;
      w.slot = slot[5:0];
      w.job_done = done;
      w.last_of_run = 1'b1;
      return w;
   endfunction

   // Work out the descriptor words that one accepted entry causes
   function automatic void build_descriptors(input sg_entry_type e);
      logic [31:0] avail;
      logic [31:0] xfer;
      logic [63:0] haddr;
      rsp_type     w;
      if (e.first_of_job) begin
         bytes_left = job_regs.job_size;
         skip_left  = job_regs.start_offset;
         dev_cursor = job_regs.device_address;
         slot_cnt   = '0;
         job_open   = 1'b1;
      end
      if (!job_open)
         return;
      // Entry lies wholly before the offset: shrink the offset, maybe close the job
      if (skip_left > e.entry_length) begin
         skip_left = skip_left - e.entry_length;
         if (e.last_entry) begin
            descriptor_queue.push_back(make_terminator(slot_cnt, 1'b1));
            slot_cnt = '0;
            job_open = 1'b0;
         end
         return;
      end
      avail = e.entry_length - skip_left;
      haddr = e.host_address + {32'd0, skip_left};
      skip_left = '0;
      xfer = (avail < bytes_left) ? avail : bytes_left;
      w = '0;
      w.slot = slot_cnt[5:0];
      w.byte_count = xfer;
      if (job_regs.to_host) begin
         w.source_address = dev_cursor;
         w.dest_address   = haddr;
      end else begin
         w.source_address = haddr;
         w.dest_address   = dev_cursor;
      end
      dev_cursor = dev_cursor + {32'd0, xfer};
      bytes_left = bytes_left - xfer;
      slot_cnt = slot_cnt + 1'b1;
      // Close the job, close a full chunk, or end the run on the data word
      if (bytes_left == 0 || e.last_entry) begin
         descriptor_queue.push_back(w);
         descriptor_queue.push_back(make_terminator(slot_cnt, 1'b1));
         slot_cnt = '0;
         job_open = 1'b0;
      end else if (slot_cnt >= CHUNK_SLOTS) begin
         descriptor_queue.push_back(w);
         descriptor_queue.push_back(make_terminator(slot_cnt, 1'b0));
         slot_cnt = '0;
      end else begin
         w.last_of_run = 1'b1;
         descriptor_queue.push_back(w);
      end
   endfunction

   function automatic void report_mismatch(input string what, input rsp_type want,
                                           input rsp_type got);
      errors++;
      if (errors <= MAX_REPORTS) begin
         $display("%0t %s", $realtime, what);
         $display("   expected term=%0b slot=%0d size=%h src=%h dst=%h done=%0b last=%0b",
                  want.is_terminator, want.slot, want.byte_count, want.source_address,
                  want.dest_address, want.job_done, want.last_of_run);
         $display("   actual   term=%0b slot=%0d size=%h src=%h dst=%h done=%0b last=%0b",
                  got.is_terminator, got.slot, got.byte_count, got.source_address,
                  got.dest_address, got.job_done, got.last_of_run);
      end
   endfunction

   function automatic int draw_wait(input int pace);
      case (pace)
         PACE_FULL:   return 0;
         PACE_RANDOM: return $urandom_range(0, 13);
         default:     return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
      endcase
   endfunction

   // Sample handshakes, predict on accepted entries, check accepted words
   always @(posedge clock) begin : watch_ports
      sg_entry_type e;
      rsp_type      got;
      rsp_type      want;
      req_taken = req_valid && !req_stall && !reset;
      rsp_taken = rsp_valid && !rsp_stall && !reset;
      if (req_taken) begin
         e.first_of_job = req_first_of_job;
         e.last_entry   = req_last_entry;
         e.host_address = req_host_address;
         e.entry_length = req_entry_length;
         items_accepted++;
         build_descriptors(e);
      end
      if (rsp_taken) begin
         got.is_terminator  = rsp_is_terminator;
         got.slot           = rsp_slot;
         got.byte_count     = rsp_byte_count;
         got.source_address = rsp_source_address;
         got.dest_address   = rsp_dest_address;
         got.job_done       = rsp_job_done;
         got.last_of_run    = rsp_last_of_run;
         if (descriptor_queue.size() == 0) begin
            report_mismatch("descriptor word with none expected", '0, got);
         end else begin
            want = descriptor_queue.pop_front();
            if (got !== want)
               report_mismatch("descriptor word mismatch", want, got);
         end
      end
   end

   // Entry driver: hold the word while stalled, advance after acceptance
   int send_gap = 0;
   int send_pace = PACE_RANDOM;

   always @(negedge clock) begin : drive_entries
      sg_entry_type e;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else if (!req_valid || req_taken) begin
         if (req_taken) begin
            if ($urandom_range(0, 39) == 0)
               send_pace = $urandom_range(PACE_FULL, PACE_SPARSE);
            send_gap = draw_wait(send_pace);
         end
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (entry_queue.size() > 0) begin
            e = entry_queue.pop_front();
            req_valid        <= 1'b1;
            req_first_of_job <= e.first_of_job;
            req_last_entry   <= e.last_entry;
            req_host_address <= e.host_address;
            req_entry_length <= e.entry_length;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver: random stalls per word, plus long hold-offs on request
   int recv_wait = 0;
   int recv_pace = PACE_RANDOM;
   int hold_left = 0;

   always @(negedge clock) begin : drive_stall
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_taken) begin
            if ($urandom_range(0, 39) == 0)
               recv_pace = $urandom_range(PACE_FULL, PACE_SPARSE);
            recv_wait = draw_wait(recv_pace);
         end
         if (holds_served != holds_asked) begin
            holds_served++;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (recv_wait > 0) begin
            recv_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_JOB_SIZE:       job_regs.job_size       = val[31:0];
         CSR_START_OFFSET:   job_regs.start_offset   = val[31:0];
         CSR_DEVICE_ADDRESS: job_regs.device_address = val;
         CSR_TO_HOST:        job_regs.to_host        = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_job(input logic [31:0] size, input logic [31:0] offset,
                          input logic [63:0] dev, input logic to_host);
      write_reg(CSR_JOB_SIZE, {32'd0, size});
      write_reg(CSR_START_OFFSET, {32'd0, offset});
      write_reg(CSR_DEVICE_ADDRESS, dev);
      write_reg(CSR_TO_HOST, {63'd0, to_host});
   endtask

   task automatic push_entry(input logic first, input logic last, input logic [63:0] host,
                             input logic [31:0] len);
      entry_queue.push_back({first, last, host, len});
      items_pushed++;
   endtask

   // Wait until every entry is taken and every expected word has come
   task automatic wait_idle();
      while (items_accepted != items_pushed || descriptor_queue.size() != 0)
         @(negedge clock);
   endtask

   // Drain, then let entries that cause no word clear the pipeline
   task automatic settle();
      wait_idle();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // One well-formed job with random content
   task automatic queue_job(input int n_entries);
      logic        last;
      logic [63:0] host;
      logic [31:0] len;
      for (int k = 0; k < n_entries; k++) begin
         last = (k == n_entries - 1) && ($urandom_range(0, 3) != 0);
         host = {$urandom, $urandom};
         if ($urandom_range(0, 15) == 0)
            host = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 4095);
         case ($urandom_range(0, 15))
            0:       len = '0;
            1:       len = '1;
            2:       len = $urandom;
            3:       len = (k == 0) ? job_regs.start_offset : $urandom_range(1, 64);
            default: len = $urandom_range(1, 2048);
         endcase
         push_entry(k == 0, last, host, len);
      end
   endtask

   task automatic random_config(input bit long_jobs);
      logic [31:0] size;
      logic [31:0] offset;
      logic [63:0] dev;
      if (long_jobs)
         size = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : ($urandom | 32'h8000_0000);
      else
         case ($urandom_range(0, 5))
            0:       size = '0;
            1:       size = '1;
            2:       size = $urandom;
            3:       size = $urandom_range(1, 64);
            default: size = $urandom_range(100, 20000);
         endcase
      case ($urandom_range(0, 11))
         0, 1, 2, 3, 4, 5: offset = '0;
         6:                offset = long_jobs ? 32'd0 : 32'hFFFF_FFFF;
         7:                offset = long_jobs ? 32'd0 : $urandom;
         default:          offset = $urandom_range(1, 3000);
      endcase
      case ($urandom_range(0, 5))
         0:       dev = '0;
         1:       dev = '1;
         2:       dev = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 65535);
         default: dev = {$urandom, $urandom};
      endcase
      set_job(size, offset, dev, 1'($urandom_range(0, 1)));
   endtask

   // Mostly jobs, some noise entries, and an occasional pause until drained
   task automatic run_random_phase(input int n_items, input bit long_jobs);
      int made;
      int n;
      made = 0;
      while (made < n_items) begin
         if ($urandom_range(0, 9) == 0) begin
            n = 1;
            push_entry($urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)),
                       {$urandom, $urandom}, $urandom_range(0, 4096));
         end else begin
            n = (long_jobs && $urandom_range(0, 2) == 0) ? $urandom_range(33, 70)
                                                          : $urandom_range(1, 8);
            queue_job(n);
         end
         made += n;
         if ($urandom_range(0, 29) == 0)
            wait_idle();
      end
   endtask

   initial begin : run_test
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Skip into the list, zero-size word at the offset, cap at the job size,
      // device cursor wrapping, ignored entries with no job
      set_job(32'd100, 32'd10, 64'hFFFF_FFFF_FFFF_FFF0, 1'b0);
      push_entry(1'b0, 1'b0, 64'h0000_0000_1000_0000, 32'd64);
      push_entry(1'b1, 1'b0, 64'h0000_0000_0000_0000, 32'd4);
      push_entry(1'b0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 32'd6);
      push_entry(1'b0, 1'b0, 64'h8000_0000_0000_0000, 32'hFFFF_FFFF);
      push_entry(1'b0, 1'b1, 64'h1234_5678_9ABC_DEF0, 32'd16);
      push_entry(1'b1, 1'b1, 64'h0000_0000_0000_4000, 32'd3);
      push_entry(1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFF8, 32'd50);
      settle();

      // Zero job size, empty entries, opposite direction
      set_job(32'd0, 32'd0, 64'd0, 1'b1);
      push_entry(1'b1, 1'b0, 64'h5555_5555_5555_5555, 32'd5);
      push_entry(1'b0, 1'b0, 64'hAAAA_AAAA_AAAA_AAAA, 32'd9);
      push_entry(1'b1, 1'b1, 64'h0000_0000_0000_0000, 32'd0);
      settle();

      // Largest job and offset, top of the device space, stray register index
      set_job(32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      write_reg(CSR_NO_SUCH_REG, 64'hFFFF_FFFF_FFFF_FFFF);
      push_entry(1'b1, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
      push_entry(1'b0, 1'b1, 64'h0000_0000_0000_0100, 32'd10);
      push_entry(1'b1, 1'b0, 64'h0000_0000_0000_0200, 32'd7);
      push_entry(1'b0, 1'b0, 64'h0000_0000_0000_0300, 32'hFFFF_FFFF);
      push_entry(1'b0, 1'b1, 64'h0000_0000_0000_0400, 32'd3);
      settle();

      // Random phases; two of them start with a long hold on the result side
      for (int p = 0; p < 12; p++) begin
         random_config(p % 3 == 0);
         if (p == 3 || p == 9)
            holds_asked++;
         run_random_phase(155, p % 3 == 0);
         settle();
      end

      if (descriptor_queue.size() != 0) begin
         errors++;
         $display("%0d descriptor words never arrived", descriptor_queue.size());
      end
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
